// File: hw/rtl/wrm_pkg.sv
// Package for the windowed RMS meter: field widths, register indexes and reset values.
// It has no dependencies. The interfaces and the top level import it.
`timescale 1ns / 1ps

package wrm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int OFFSET_W   = 12;
  localparam int GAIN_W     = 32;
  localparam int WLEN_W     = 11;
  localparam int RAW_W      = 20;
  localparam int SCALED_W   = 28;
  localparam int SUM_W      = 35;
  localparam int MAX_WINDOW = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd2;

  localparam logic [OFFSET_W-1:0] ZERO_OFFSET_RST   = 12'd2048;
  localparam logic [GAIN_W-1:0]   GAIN_RST          = 32'h0100_0000;
  localparam logic [WLEN_W-1:0]   WINDOW_LENGTH_RST = 11'd100;

endpackage

// File: hw/rtl/wrm_sample_if.sv
// Input channel of the windowed RMS meter: one raw ADC sample per item.
// Depends on wrm_pkg for the sample width.
`timescale 1ns / 1ps

interface wrm_sample_if;
  import wrm_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: hw/rtl/wrm_result_if.sv
// Result channel of the windowed RMS meter: raw and scaled RMS per item.
// Depends on wrm_pkg for the field widths.
`timescale 1ns / 1ps

interface wrm_result_if;
  import wrm_pkg::*;

  logic                valid;
  logic                ready;
  logic [RAW_W-1:0]    rms_raw;
  logic [SCALED_W-1:0] rms_scaled;

  modport source (output valid, output rms_raw, output rms_scaled, input ready);
  modport sink   (input valid, input rms_raw, input rms_scaled, output ready);
endinterface

// File: hw/rtl/windowed_rms_meter.sv
// Windowed RMS meter: squares centred ADC samples, then divides, roots and scales per window.
// Depends on wrm_pkg, wrm_sample_if and wrm_result_if.
//
// Usage:
// Samples enter on in_ch and results leave on out_ch, both valid/ready channels.
// Registers are written through cfg_we, cfg_index and cfg_data: zero offset (0),
// gain (1) and window length (2). Write them only while the block is idle.
// Each sample is squared by a shared shift-and-add multiplier that retires one
// multiplier bit a cycle. The block therefore takes a new sample only after the
// previous one has been squared and added to the window sum. On the last sample
// of a window, a restoring divider produces one quotient bit a cycle. An integer
// square root then produces one root bit a cycle, and the shared multiplier
// applies the gain. No sample is taken until the result has been registered.
// The result is held in an output register. The block takes new samples while
// the result waits. If the receiver stalls when the next window completes, the
// block holds its finished result and takes no samples until out_ch.ready is high.
// A synchronous reset (rst_n low) restores the default registers, empties the
// window and drops any pending result.
`timescale 1ns / 1ps

module windowed_rms_meter (
  input  logic                            clk,
  input  logic                            rst_n,
  wrm_sample_if.sink                      in_ch,
  wrm_result_if.source                    out_ch,
  input  logic                            cfg_we,
  input  logic [wrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wrm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wrm_pkg::*;

  localparam int WORK_W = 52;
  localparam int ROOT_W = 26;
  localparam int SREM_W = 28;
  localparam int CNT_W  = 6;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQR, ST_ACC, ST_DIV, ST_SQRT, ST_SCL, ST_FIN
  } state_t;

  state_t                state_r;
  logic [OFFSET_W-1:0]   zero_offset_r;
  logic [GAIN_W-1:0]     gain_r;
  logic [WLEN_W-1:0]     window_length_r;
  logic [SUM_W-1:0]      sum_r;
  logic [WLEN_W-1:0]     idx_r;
  logic [WLEN_W-1:0]     len_r;
  logic [WORK_W-1:0]     work_r;
  logic [WLEN_W-1:0]     div_rem_r;
  logic [SREM_W-1:0]     sq_rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [GAIN_W-1:0]     mul_a_r;
  logic [GAIN_W-1:0]     mul_hi_r;
  logic [RAW_W-1:0]      mul_lo_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [RAW_W-1:0]      rms_r;
  logic                  out_valid_r;
  logic [RAW_W-1:0]      out_raw_r;
  logic [SCALED_W-1:0]   out_scaled_r;

  logic [SAMPLE_W-1:0]   mag_nxt;
  logic [WLEN_W-1:0]     eff_len_nxt;
  logic [GAIN_W:0]       mul_sum_nxt;
  logic [SUM_W-1:0]      sum_nxt;
  logic [WLEN_W-1:0]     idx_nxt;
  logic [WLEN_W:0]       div_sh_nxt;
  logic                  div_ge_nxt;
  logic [WLEN_W:0]       div_diff_nxt;
  logic [SREM_W-1:0]     sq_sh_nxt;
  logic [SREM_W-1:0]     sq_trial_nxt;
  logic                  sq_ge_nxt;
  logic [ROOT_W-1:0]     root_nxt;
  logic [RAW_W-1:0]      rms_nxt;
  logic                  in_fire;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = rst_n && (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.rms_raw    = out_raw_r;
  assign out_ch.rms_scaled = out_scaled_r;

  always_comb begin
    if (in_ch.sample >= zero_offset_r) begin
      mag_nxt = in_ch.sample - zero_offset_r;
    end else begin
      mag_nxt = zero_offset_r - in_ch.sample;
    end

    if (window_length_r == '0) begin
      eff_len_nxt = WLEN_W'(1);
    end else if (window_length_r > WLEN_W'(MAX_WINDOW)) begin
      eff_len_nxt = WLEN_W'(MAX_WINDOW);
    end else begin
      eff_len_nxt = window_length_r;
    end

    mul_sum_nxt = {1'b0, mul_hi_r} + (mul_lo_r[0] ? {1'b0, mul_a_r} : '0);
    sum_nxt     = sum_r + {11'b0, mul_hi_r[3:0], mul_lo_r};
    idx_nxt     = idx_r + WLEN_W'(1);

    div_sh_nxt   = {div_rem_r, work_r[WORK_W-1]};
    div_ge_nxt   = (div_sh_nxt >= {1'b0, len_r});
    div_diff_nxt = div_sh_nxt - {1'b0, len_r};

    sq_sh_nxt    = {sq_rem_r[SREM_W-3:0], work_r[WORK_W-1:WORK_W-2]};
    sq_trial_nxt = {root_r, 2'b01};
    sq_ge_nxt    = (sq_sh_nxt >= sq_trial_nxt);
    root_nxt     = {root_r[ROOT_W-2:0], sq_ge_nxt};
    if (root_nxt[ROOT_W-1:RAW_W] != '0) begin
      rms_nxt = '1;
    end else begin
      rms_nxt = root_nxt[RAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      zero_offset_r   <= ZERO_OFFSET_RST;
      gain_r          <= GAIN_RST;
      window_length_r <= WINDOW_LENGTH_RST;
      sum_r           <= '0;
      idx_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ZERO_OFFSET:   zero_offset_r   <= cfg_data[OFFSET_W-1:0];
          CFG_GAIN:          gain_r          <= cfg_data[GAIN_W-1:0];
          CFG_WINDOW_LENGTH: window_length_r <= cfg_data[WLEN_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ch.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            mul_a_r  <= {{(GAIN_W-SAMPLE_W){1'b0}}, mag_nxt};
            mul_lo_r <= {{(RAW_W-SAMPLE_W){1'b0}}, mag_nxt};
            mul_hi_r <= '0;
            cnt_r    <= CNT_W'(RAW_W - 1);
            state_r  <= ST_SQR;
          end
        end
        ST_SQR, ST_SCL: begin
          mul_hi_r <= mul_sum_nxt[GAIN_W:1];
          mul_lo_r <= {mul_sum_nxt[0], mul_lo_r[RAW_W-1:1]};
          cnt_r    <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= (state_r == ST_SQR) ? ST_ACC : ST_FIN;
          end
        end
        ST_ACC: begin
          if (idx_nxt >= eff_len_nxt) begin
            work_r    <= {1'b0, sum_nxt, 16'b0};
            len_r     <= eff_len_nxt;
            div_rem_r <= '0;
            cnt_r     <= CNT_W'(WORK_W - 1);
            sum_r     <= '0;
            idx_r     <= '0;
            state_r   <= ST_DIV;
          end else begin
            sum_r   <= sum_nxt;
            idx_r   <= idx_nxt;
            state_r <= ST_IDLE;
          end
        end
        ST_DIV: begin
          div_rem_r <= div_ge_nxt ? div_diff_nxt[WLEN_W-1:0] : div_sh_nxt[WLEN_W-1:0];
          work_r    <= {work_r[WORK_W-2:0], div_ge_nxt};
          if (cnt_r == '0) begin
            sq_rem_r <= '0;
            root_r   <= '0;
            cnt_r    <= CNT_W'(ROOT_W - 1);
            state_r  <= ST_SQRT;
          end else begin
            cnt_r    <= cnt_r - CNT_W'(1);
          end
        end
        ST_SQRT: begin
          sq_rem_r <= sq_ge_nxt ? (sq_sh_nxt - sq_trial_nxt) : sq_sh_nxt;
          root_r   <= root_nxt;
          work_r   <= {work_r[WORK_W-3:0], 2'b00};
          if (cnt_r == '0) begin
            rms_r    <= rms_nxt;
            mul_a_r  <= gain_r;
            mul_lo_r <= rms_nxt;
            mul_hi_r <= '0;
            cnt_r    <= CNT_W'(RAW_W - 1);
            state_r  <= ST_SCL;
          end else begin
            cnt_r    <= cnt_r - CNT_W'(1);
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_raw_r    <= rms_r;
            out_scaled_r <= mul_hi_r[GAIN_W-1:24-RAW_W];
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // A sample that is taken starts the squaring pass on the next cycle.
  a_sample_starts_square: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_SQR)
    else $error("accepted sample did not start squaring");

  // The square of a sample never exceeds 24 bits.
  a_square_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC |-> mul_hi_r[GAIN_W-1:4] == '0)
    else $error("sample square overflowed");

  // The restoring divider keeps its remainder below a valid divisor.
  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> len_r != '0 && len_r <= WLEN_W'(MAX_WINDOW) && div_rem_r < len_r)
    else $error("divider remainder out of range");

  // The root remainder never exceeds twice the partial root.
  a_sqrt_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQRT |-> sq_rem_r <= {1'b0, root_r, 1'b0})
    else $error("square root remainder out of range");

endmodule
